// File: rtl/core/mct_pkg.sv
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants of the mouse cursor tracker: payload structs,
// register map, reset values and the command bundle between control and
// datapath.
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_SCREEN_W = 2'd0;
  localparam logic [1:0] REG_SCREEN_H = 2'd1;
  localparam logic [1:0] REG_SCALE_N  = 2'd2;
  localparam logic [1:0] REG_SCALE_D  = 2'd3;

  localparam logic [12:0] SCREEN_W_RST = 13'd640;
  localparam logic [12:0] SCREEN_H_RST = 13'd480;
  localparam logic [7:0]  SCALE_N_RST  = 8'd1;
  localparam logic [7:0]  SCALE_D_RST  = 8'd1;
  localparam logic [12:0] SCREEN_MAX   = 13'd4096;

  localparam logic [11:0] POS_X_RST = 12'(SCREEN_W_RST / 2);
  localparam logic [11:0] POS_Y_RST = 12'(SCREEN_H_RST / 2);

  // magnitude of delta * numerator + carry, two quotient bits per step
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned DIV_STEPS = MAG_W / 2;

  typedef struct packed {
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [2:0]         button_mask;
  } in_t;

  typedef struct packed {
    logic [11:0] cursor_x;
    logic [11:0] cursor_y;
    logic        moved;
    logic [2:0]  buttons_now;
    logic [2:0]  pressed_mask;
    logic [2:0]  released_mask;
  } out_t;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [11:0] max_x;
    logic [11:0] max_y;
    logic [11:0] ctr_x;
    logic [11:0] ctr_y;
    logic [7:0]  num;
    logic [7:0]  den;
    logic        recenter;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic load;
    logic div_step;
    logic update;
    logic axis;      // 0: X, 1: Y
    logic emit;
  } cmd_t;

endpackage

// File: rtl/core/mct_regs.sv
// ----------------------------------------------------------------------------
// mct_regs
// APB-style register file: screen size and scale factors, with the
// effective (range-limited) values and a recentre pulse for the datapath.
// ----------------------------------------------------------------------------
module mct_regs
  import mct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [7:0]  num_r;
  logic [7:0]  den_r;
  logic        recenter_r;
  logic        wr_en;
  logic [1:0]  idx;
  logic [12:0] eff_w;
  logic [12:0] eff_h;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= SCREEN_W_RST;
      height_r   <= SCREEN_H_RST;
      num_r      <= SCALE_N_RST;
      den_r      <= SCALE_D_RST;
      recenter_r <= 1'b0;
    end else begin
      recenter_r <= 1'b0;
      if (wr_en) begin
        case (idx)
          REG_SCREEN_W: begin
            width_r    <= pwdata[12:0];
            recenter_r <= 1'b1;
          end
          REG_SCREEN_H: begin
            height_r   <= pwdata[12:0];
            recenter_r <= 1'b1;
          end
          REG_SCALE_N: num_r <= pwdata[7:0];
          REG_SCALE_D: den_r <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_SCREEN_W: prdata = {19'd0, width_r};
      REG_SCREEN_H: prdata = {19'd0, height_r};
      REG_SCALE_N:  prdata = {24'd0, num_r};
      REG_SCALE_D:  prdata = {24'd0, den_r};
      default:      prdata = '0;
    endcase
  end

  // zero counts as one, oversize as the maximum, in the effective size
  assign eff_w = (width_r == 13'd0) ? 13'd1 :
                 (width_r > SCREEN_MAX) ? SCREEN_MAX : width_r;
  assign eff_h = (height_r == 13'd0) ? 13'd1 :
                 (height_r > SCREEN_MAX) ? SCREEN_MAX : height_r;

  always_comb begin
    cfg.max_x    = 12'(eff_w - 13'd1);
    cfg.max_y    = 12'(eff_h - 13'd1);
    cfg.ctr_x    = eff_w[12:1];
    cfg.ctr_y    = eff_h[12:1];
    cfg.num      = num_r;
    cfg.den      = (den_r == 8'd0) ? 8'd1 : den_r;
    cfg.recenter = recenter_r;
  end

endmodule

// File: rtl/core/mct_ctrl.sv
// ----------------------------------------------------------------------------
// mct_ctrl
// Sequencer: scales X then Y through the shared divider, then hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module mct_ctrl
  import mct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic       axis_r, axis_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.axis      = axis_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_nxt    = 1'b0;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'(DIV_STEPS - 1)) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/mct_dp.sv
// ----------------------------------------------------------------------------
// mct_dp
// Datapath: scale multiply, shared radix-4 restoring divider on the
// magnitude, sign restore, clamp, cursor state and the output register.
// ----------------------------------------------------------------------------
module mct_dp
  import mct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  cfg_t cfg,
  input  in_t  in_data,
  output out_t out_data
);

  in_t                in_r;
  out_t               out_r;
  logic signed [24:0] acc_r;
  logic               neg_r;
  logic [MAG_W-1:0]   quo_r, quo_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic [11:0]        pos_x_r, pos_y_r;
  logic signed [8:0]  carry_x_r, carry_y_r;
  logic [2:0]         last_btn_r;
  logic               moved_r;

  logic signed [15:0] delta_sel;
  logic signed [8:0]  carry_sel;
  logic [11:0]        pos_sel;
  logic [11:0]        max_sel;
  logic signed [24:0] delta_ext, num_ext, prod, acc_nxt, mag_full;
  logic [8:0]         trial;
  logic signed [24:0] q_pos, q_sgn, sum;
  logic [11:0]        pos_new;
  logic signed [8:0]  rem9, carry_new;

  assign delta_sel = cmd.axis ? in_r.delta_y : in_r.delta_x;
  assign carry_sel = cmd.axis ? carry_y_r : carry_x_r;
  assign pos_sel   = cmd.axis ? pos_y_r : pos_x_r;
  assign max_sel   = cmd.axis ? cfg.max_y : cfg.max_x;

  assign delta_ext = {{9{delta_sel[15]}}, delta_sel};
  assign num_ext   = $signed({17'd0, cfg.num});
  assign prod      = delta_ext * num_ext;
  assign acc_nxt   = prod + {{16{carry_sel[8]}}, carry_sel};
  assign mag_full  = acc_r[24] ? -acc_r : acc_r;

  // two quotient bits per cycle; partial remainder stays below the divisor
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_nxt, quo_nxt[MAG_W-1]};
      if (trial >= {1'b0, cfg.den}) begin
        rem_nxt = 8'(trial - {1'b0, cfg.den});
        quo_nxt = {quo_nxt[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[7:0];
        quo_nxt = {quo_nxt[MAG_W-2:0], 1'b0};
      end
    end
  end

  // truncation toward zero: quotient and remainder take the dividend's sign
  assign q_pos     = $signed({1'b0, quo_r});
  assign q_sgn     = neg_r ? -q_pos : q_pos;
  assign sum       = $signed({13'd0, pos_sel}) + q_sgn;
  assign rem9      = $signed({1'b0, rem_r});
  assign carry_new = neg_r ? -rem9 : rem9;

  always_comb begin
    if (sum[24])                              pos_new = 12'd0;
    else if (sum > $signed({13'd0, max_sel})) pos_new = max_sel;
    else                                      pos_new = sum[11:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r    <= POS_X_RST;
      pos_y_r    <= POS_Y_RST;
      carry_x_r  <= '0;
      carry_y_r  <= '0;
      last_btn_r <= '0;
      moved_r    <= 1'b0;
    end else if (cfg.recenter) begin
      // a report may be taken in the same cycle as the recentre
      if (cmd.capture) moved_r <= 1'b0;
      pos_x_r    <= cfg.ctr_x;
      pos_y_r    <= cfg.ctr_y;
      carry_x_r  <= '0;
      carry_y_r  <= '0;
      last_btn_r <= '0;
    end else begin
      if (cmd.capture) moved_r <= 1'b0;
      if (cmd.update) begin
        moved_r <= moved_r | (pos_new != pos_sel);
        if (cmd.axis) begin
          pos_y_r   <= pos_new;
          carry_y_r <= carry_new;
        end else begin
          pos_x_r   <= pos_new;
          carry_x_r <= carry_new;
        end
      end
      if (cmd.emit) last_btn_r <= in_r.button_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.mul) acc_r <= acc_nxt;
    if (cmd.load) begin
      quo_r <= mag_full[MAG_W-1:0];
      neg_r <= acc_r[24];
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.emit) begin
      out_r.cursor_x      <= pos_x_r;
      out_r.cursor_y      <= pos_y_r;
      out_r.moved         <= moved_r;
      out_r.buttons_now   <= in_r.button_mask;
      out_r.pressed_mask  <= in_r.button_mask & ~last_btn_r;
      out_r.released_mask <= last_btn_r & ~in_r.button_mask;
    end
  end

  assign out_data = out_r;

endmodule

// File: rtl/core/mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// mouse_cursor_tracker
// Turns mouse reports into a clamped cursor position with button edges.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one mouse report per transaction (delta_x, delta_y, button_mask).
//   out_* : one result per report: position, moved flag, buttons and the
//           newly pressed and released masks.
//   APB   : screen width/height at 0x0/0x4 (writing recentres the cursor and
//           clears remainders and button history), scale numerator at 0x8,
//           denominator at 0xC. pready is tied high.
// Sequence: once a report is accepted, per axis a multiply, a load, the
//   divider steps (two quotient bits each) and an update, then the move
//   into the output register; after that the next report can be taken.
//   The single shared divider keeps one report in work at a time.
// A finished result sits in the output register, so the next report is
//   taken and worked while the receiver stalls; it then waits at the end
//   until the register frees.
// Reset: 640x480 screen, cursor at 320,240, scale 1/1, no result pending.
// ----------------------------------------------------------------------------
module mouse_cursor_tracker
  import mct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;

  mct_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mct_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/mct_checker.sv
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks of the cursor tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mct_checker
  import mct_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data,
  input logic pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // one report in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second report taken while busy");

  // a fresh result cannot follow an acceptance in the next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind mouse_cursor_tracker mct_checker u_mct_checker (.*);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives mouse reports into the cursor tracker under a series of screen and
// scale settings written over APB, predicts every result and checks each one
// field by field as it leaves the block. Random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import mct_pkg::*;

  localparam int CYCLE_LIMIT = 1200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_PHASES = 14;
  localparam int REPORTS_PER_PHASE = 100;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mouse_cursor_tracker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // tracker state as the block should hold it
  logic [12:0] scr_w, scr_h;
  logic [7:0]  gain_num, gain_den;
  int          cur_x, cur_y, rem_x, rem_y;
  logic [2:0]  prev_buttons;

  in_t  queued_reports[$];
  out_t predicted_cursor[$];
  int   reports_queued = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   send_gap = 0;
  int   hold_left = 0;
  logic in_fire = 1'b0;
  logic in_steady = 1'b0;
  logic out_steady = 1'b0;

  function automatic int eff_size(logic [12:0] s);
    if (s == 13'd0) return 1;
    if (s > SCREEN_MAX) return 4096;
    return int'(s);
  endfunction

  function automatic void recentre();
    cur_x = eff_size(scr_w) / 2;
    cur_y = eff_size(scr_h) / 2;
    rem_x = 0;
    rem_y = 0;
    prev_buttons = 3'b000;
  endfunction

  // one axis: scale, add carried remainder, divide toward zero, clamp
  function automatic int scale_axis(int delta, inout int rem, input int pos, input int size);
    int dv, acc, q, p;
    dv = (gain_den == 8'd0) ? 1 : int'(gain_den);
    acc = delta * int'(gain_num) + rem;
    q = acc / dv;
    rem = acc - q * dv;
    p = pos + q;
    if (p < 0) p = 0;
    if (p > size - 1) p = size - 1;
    return p;
  endfunction

  function automatic out_t track_report(in_t r);
    out_t res;
    int dx, dy, nx, ny;
    dx = r.delta_x;
    dy = r.delta_y;
    nx = scale_axis(dx, rem_x, cur_x, eff_size(scr_w));
    ny = scale_axis(dy, rem_y, cur_y, eff_size(scr_h));
    res.moved = (nx != cur_x) || (ny != cur_y);
    cur_x = nx;
    cur_y = ny;
    res.cursor_x = nx[11:0];
    res.cursor_y = ny[11:0];
    res.buttons_now = r.button_mask;
    res.pressed_mask = r.button_mask & ~prev_buttons;
    res.released_mask = prev_buttons & ~r.button_mask;
    prev_buttons = r.button_mask;
    return res;
  endfunction

  function automatic void report_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("result %0d: %s", results_seen, msg);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) report_error($sformatf("%s expected %0d got %0d", name, want, got));
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    if (predicted_cursor.size() == 0) begin
      report_error($sformatf("unexpected transaction %p", got));
      return;
    end
    want = predicted_cursor.pop_front();
    check_field("cursor_x", want.cursor_x, got.cursor_x);
    check_field("cursor_y", want.cursor_y, got.cursor_y);
    check_field("moved", want.moved, got.moved);
    check_field("buttons_now", want.buttons_now, got.buttons_now);
    check_field("pressed_mask", want.pressed_mask, got.pressed_mask);
    check_field("released_mask", want.released_mask, got.released_mask);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // sampling side: acceptance, prediction, checking, timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      in_fire <= in_valid && in_ready;
      if (rst_n && in_valid && in_ready) predicted_cursor.push_back(track_report(in_data));
      if (rst_n && out_valid && out_ready) begin
        check_result(out_data);
        results_seen++;
      end
    end
  end

  // report driver: holds a transaction until taken, then an optional gap
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (queued_reports.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= queued_reports.pop_front();
        send_gap <= in_steady ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!out_steady && $urandom_range(0, 99) < 20) hold_left <= pick_gap();
    end
  end

  task automatic queue_report(int dx, int dy, int buttons);
    in_t r;
    r.delta_x = 16'(dx);
    r.delta_y = 16'(dy);
    r.button_mask = 3'(buttons);
    queued_reports.push_back(r);
    reports_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen < reports_queued) @(negedge clk);
  endtask

  // APB write: setup, access, then the register takes the value
  task automatic write_reg(logic [1:0] idx, int unsigned value);
    logic [31:0] junk;
    logic        is_scale;
    is_scale = (idx == REG_SCALE_N) || (idx == REG_SCALE_D);
    junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
    junk = junk & (is_scale ? 32'hFFFF_FF00 : 32'hFFFF_E000);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value | junk;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SCREEN_W: begin
        scr_w = value[12:0];
        recentre();
      end
      REG_SCREEN_H: begin
        scr_h = value[12:0];
        recentre();
      end
      REG_SCALE_N: gain_num = value[7:0];
      REG_SCALE_D: gain_den = value[7:0];
      default: ;
    endcase
  endtask

  function automatic int pick_screen();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 4096;
    if (r == 2) return $urandom_range(4097, 8191);
    if (r < 6) return $urandom_range(1, 64);
    return $urandom_range(1, 4096);
  endfunction

  function automatic int pick_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    if (r == 2) return 1;
    if (r < 6) return $urandom_range(1, 16);
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_delta();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return $urandom_range(0, 16) - 8;
    if (r < 14) return $urandom_range(0, 600) - 300;
    if (r < 17) return int'($signed(16'($urandom())));
    if (r == 17) return -32768;
    if (r == 18) return 32767;
    return $urandom_range(0, 2) - 1;
  endfunction

  initial begin
    int buttons;
    scr_w = SCREEN_W_RST;
    scr_h = SCREEN_H_RST;
    gain_num = SCALE_N_RST;
    gain_den = SCALE_D_RST;
    recentre();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: clamping at both edges, button edges
    queue_report(0, 0, 0);
    queue_report(1, -1, 3'b001);
    queue_report(32767, -32768, 3'b011);
    queue_report(32767, -32768, 3'b011);
    queue_report(-32768, 32767, 3'b100);
    queue_report(-1, 1, 3'b111);
    wait_drained();

    // fractional scale builds up remainders of both signs
    write_reg(REG_SCALE_N, 3);
    write_reg(REG_SCALE_D, 7);
    queue_report(5, -5, 3'b111);
    queue_report(2, -2, 3'b000);
    queue_report(1, -1, 3'b000);
    wait_drained();

    // zero numerator, new denominator: carried remainder still divides out
    write_reg(REG_SCALE_N, 0);
    write_reg(REG_SCALE_D, 2);
    queue_report(100, -100, 3'b001);
    queue_report(-5, 5, 3'b001);
    wait_drained();

    // zero denominator acts as one
    write_reg(REG_SCALE_D, 0);
    write_reg(REG_SCALE_N, 255);
    queue_report(128, -128, 3'b010);
    queue_report(-1, 1, 3'b010);
    wait_drained();

    // zero and oversized screen, recentre with a button held
    write_reg(REG_SCREEN_W, 0);
    write_reg(REG_SCREEN_H, 8191);
    queue_report(1, 1, 3'b010);
    queue_report(-32768, 32767, 3'b000);
    wait_drained();

    write_reg(REG_SCREEN_W, 4096);
    write_reg(REG_SCREEN_H, 4096);
    write_reg(REG_SCALE_N, 1);
    write_reg(REG_SCALE_D, 255);
    queue_report(32767, 32767, 3'b101);
    queue_report(-300, 300, 3'b101);
    queue_report(-32768, -32768, 3'b010);
    wait_drained();

    write_reg(REG_SCREEN_W, 1);
    write_reg(REG_SCREEN_H, 1);
    queue_report(7, -7, 3'b111);
    wait_drained();

    // random phases, each after optional new settings written once the block is empty
    buttons = 0;
    for (int ph = 0; ph < REPORT_PHASES; ph++) begin
      if ($urandom_range(0, 1)) write_reg(REG_SCREEN_W, pick_screen());
      if ($urandom_range(0, 1)) write_reg(REG_SCREEN_H, pick_screen());
      if ($urandom_range(0, 4) < 3) write_reg(REG_SCALE_N, pick_scale());
      if ($urandom_range(0, 4) < 3) write_reg(REG_SCALE_D, pick_scale());
      in_steady = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < REPORTS_PER_PHASE; k++) begin
        if ($urandom_range(0, 9) < 7) buttons = $urandom_range(0, 7);
        queue_report(pick_delta(), pick_delta(), buttons);
      end
      wait_drained();
    end

    in_steady = 1'b0;
    out_steady = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && predicted_cursor.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
